FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: design/e321_pkg.sv
// Types, constants and rounding helpers for the Euler 3-2-1 to DCM core.
package e321_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int CORDIC_STEPS   = 30;
  localparam int TW             = 32;
  localparam int PW             = 64;
  localparam int OW             = COEF_FRAC_BITS + 2;
  localparam int SC_LAT         = CORDIC_STEPS + 2;
  localparam int MAT_STAGES     = 5;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [TW-1:0]         trig_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [OW-1:0]         coef_t;

  typedef struct packed {
    logic vld;
    logic cmd;
  } ctl_t;

  localparam trig_t CORDIC_X0 = 32'sd652032874;
  localparam prod_t COEF_LIM  = prod_t'(1) <<< COEF_FRAC_BITS;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  function automatic trig_t rnd_q30(prod_t p);
    prod_t s;
    s = p + (prod_t'(1) <<< 29);
    return s[30 +: TW];
  endfunction

  function automatic coef_t to_coef(prod_t v);
    prod_t s;
    prod_t r;
    s = v + (prod_t'(1) <<< (59 - COEF_FRAC_BITS));
    r = s >>> (60 - COEF_FRAC_BITS);
    if (r > COEF_LIM) begin
      r = COEF_LIM;
    end else if (r < -COEF_LIM) begin
      r = -COEF_LIM;
    end
    return coef_t'(r);
  endfunction

endpackage

FILE: design/euler_321_to_dcm_core.sv
// Top level: 3-2-1 Euler angles to direction cosine matrix, fully pipelined.
// Takes roll, pitch and yaw as 16-bit binary angles (32768 = pi) and returns the nine
// entries of the NED-to-body matrix (in_cmd = 0) or its transpose, body-to-NED
// (in_cmd = 1), as saturated Q1.14 values. One item enters per cycle unless the pipeline
// holds. The path has 37 register stages: 32 of CORDIC (an input stage, thirty
// micro-rotations and a quadrant fix-up) and 5 of products, sums and rounding.
// The whole pipeline holds while a result waits on out_ready; empty slots carry no item.
`include "assert_macros.svh"
module euler_321_to_dcm_core import e321_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_cmd,
  input  angle_t in_roll_angle,
  input  angle_t in_pitch_angle,
  input  angle_t in_yaw_angle,
  output logic   out_valid,
  input  logic   out_ready,
  output coef_t  out_m00,
  output coef_t  out_m01,
  output coef_t  out_m02,
  output coef_t  out_m10,
  output coef_t  out_m11,
  output coef_t  out_m12,
  output coef_t  out_m20,
  output coef_t  out_m21,
  output coef_t  out_m22
);

  localparam coef_t COEF_MAX = coef_t'(COEF_LIM);

  logic  en;
  ctl_t  sc_ctl_r [SC_LAT];
  ctl_t  mat_ctl;
  trig_t cx, sx, cy, sy, cz, sz;
  coef_t m [9];

  assign en       = !mat_ctl.vld || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SC_LAT; k++) begin
        sc_ctl_r[k] <= '0;
      end
    end else if (en) begin
      sc_ctl_r[0] <= '{vld: in_valid, cmd: in_cmd};
      for (int k = 1; k < SC_LAT; k++) begin
        sc_ctl_r[k] <= sc_ctl_r[k-1];
      end
    end
  end

  e321_sincos u_roll (
    .clk   (clk),
    .en    (en),
    .angle (in_roll_angle),
    .cos_o (cx),
    .sin_o (sx)
  );

  e321_sincos u_pitch (
    .clk   (clk),
    .en    (en),
    .angle (in_pitch_angle),
    .cos_o (cy),
    .sin_o (sy)
  );

  e321_sincos u_yaw (
    .clk   (clk),
    .en    (en),
    .angle (in_yaw_angle),
    .cos_o (cz),
    .sin_o (sz)
  );

  e321_matrix u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (sc_ctl_r[SC_LAT-1]),
    .cx    (cx),
    .sx    (sx),
    .cy    (cy),
    .sy    (sy),
    .cz    (cz),
    .sz    (sz),
    .ctl_o (mat_ctl),
    .m_o   (m)
  );

  assign out_valid = mat_ctl.vld;
  assign out_m00   = m[0];
  assign out_m01   = m[1];
  assign out_m02   = m[2];
  assign out_m10   = m[3];
  assign out_m11   = m[4];
  assign out_m12   = m[5];
  assign out_m20   = m[6];
  assign out_m21   = m[7];
  assign out_m22   = m[8];

  `ASSERT_AT(a_stall_blocks_input, clk, rst_n, (out_valid && !out_ready) |-> !in_ready)
  `ASSERT_AT(a_bubble_enters_empty, clk, rst_n, (in_ready && !in_valid) |=> !sc_ctl_r[0].vld)
  `ASSERT_NEVER(a_m22_in_range, clk, rst_n, out_valid && (out_m22 > COEF_MAX || out_m22 < -COEF_MAX))
  `ASSERT_AT(a_hold_pipe_on_stall, clk, rst_n, !en |=> $stable(sc_ctl_r[SC_LAT-1]))

endmodule

FILE: design/e321_sincos.sv
// Pipelined CORDIC sine and cosine of one binary angle.
module e321_sincos import e321_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  angle_t angle,
  output trig_t  cos_o,
  output trig_t  sin_o
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [31:0] a;
  logic [31:0] a_q;
  logic [1:0]  q;
  logic [31:0] u;

  trig_t      x_r [CORDIC_STEPS+1];
  trig_t      y_r [CORDIC_STEPS+1];
  trig_t      z_r [CORDIC_STEPS+1];
  logic [1:0] q_r [CORDIC_STEPS+1];
  trig_t      cos_nxt, sin_nxt, cos_r, sin_r;

  assign a   = {angle, {(32-ANGLE_BITS){1'b0}}};
  assign a_q = a + 32'h2000_0000;
  assign q   = a_q[31:30];
  assign u   = a - {q, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_X0;
      y_r[0] <= '0;
      z_r[0] <= trig_t'(u);
      q_r[0] <= q;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    trig_t dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][TW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - trig_t'(ATAN_TAB[i]);
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + trig_t'(ATAN_TAB[i]);
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  always_comb begin
    unique case (q_r[CORDIC_STEPS])
      QUAD_0: begin
        cos_nxt = x_r[CORDIC_STEPS];
        sin_nxt = y_r[CORDIC_STEPS];
      end
      QUAD_1: begin
        cos_nxt = -y_r[CORDIC_STEPS];
        sin_nxt = x_r[CORDIC_STEPS];
      end
      QUAD_2: begin
        cos_nxt = -x_r[CORDIC_STEPS];
        sin_nxt = -y_r[CORDIC_STEPS];
      end
      QUAD_3: begin
        cos_nxt = y_r[CORDIC_STEPS];
        sin_nxt = -x_r[CORDIC_STEPS];
      end
      default: begin
        cos_nxt = x_r[CORDIC_STEPS];
        sin_nxt = y_r[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

FILE: design/e321_matrix.sv
// Product, sum and rounding pipeline that forms the nine matrix entries.
module e321_matrix import e321_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_i,
  input  trig_t cx,
  input  trig_t sx,
  input  trig_t cy,
  input  trig_t sy,
  input  trig_t cz,
  input  trig_t sz,
  output ctl_t  ctl_o,
  output coef_t m_o [9]
);

  ctl_t  ctl_r [MAT_STAGES];

  prod_t p_cycz1_r, p_cysz1_r, p_cysx1_r, p_cycx1_r;
  prod_t p_szcx1_r, p_czcx1_r, p_szsx1_r, p_czsx1_r;
  prod_t p_sysx1_r, p_sycx1_r;
  trig_t sy1_r, sz1_r, cz1_r;

  prod_t p_cycz2_r, p_cysz2_r, p_cysx2_r, p_cycx2_r;
  prod_t p_szcx2_r, p_czcx2_r, p_szsx2_r, p_czsx2_r;
  trig_t sysx2_r, sycx2_r, sy2_r, sz2_r, cz2_r;

  prod_t p_cycz3_r, p_cysz3_r, p_cysx3_r, p_cycx3_r;
  prod_t p_szcx3_r, p_czcx3_r, p_szsx3_r, p_czsx3_r;
  prod_t t_sysxcz3_r, t_sysxsz3_r, t_sycxcz3_r, t_sycxsz3_r;
  trig_t sy3_r;

  prod_t m4_r [9];
  coef_t m5_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAT_STAGES; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < MAT_STAGES; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cycz1_r <= cy * cz;
      p_cysz1_r <= cy * sz;
      p_cysx1_r <= cy * sx;
      p_cycx1_r <= cy * cx;
      p_szcx1_r <= sz * cx;
      p_czcx1_r <= cz * cx;
      p_szsx1_r <= sz * sx;
      p_czsx1_r <= cz * sx;
      p_sysx1_r <= sy * sx;
      p_sycx1_r <= sy * cx;
      sy1_r     <= sy;
      sz1_r     <= sz;
      cz1_r     <= cz;

      p_cycz2_r <= p_cycz1_r;
      p_cysz2_r <= p_cysz1_r;
      p_cysx2_r <= p_cysx1_r;
      p_cycx2_r <= p_cycx1_r;
      p_szcx2_r <= p_szcx1_r;
      p_czcx2_r <= p_czcx1_r;
      p_szsx2_r <= p_szsx1_r;
      p_czsx2_r <= p_czsx1_r;
      sysx2_r   <= rnd_q30(p_sysx1_r);
      sycx2_r   <= rnd_q30(p_sycx1_r);
      sy2_r     <= sy1_r;
      sz2_r     <= sz1_r;
      cz2_r     <= cz1_r;

      p_cycz3_r   <= p_cycz2_r;
      p_cysz3_r   <= p_cysz2_r;
      p_cysx3_r   <= p_cysx2_r;
      p_cycx3_r   <= p_cycx2_r;
      p_szcx3_r   <= p_szcx2_r;
      p_czcx3_r   <= p_czcx2_r;
      p_szsx3_r   <= p_szsx2_r;
      p_czsx3_r   <= p_czsx2_r;
      t_sysxcz3_r <= sysx2_r * cz2_r;
      t_sysxsz3_r <= sysx2_r * sz2_r;
      t_sycxcz3_r <= sycx2_r * cz2_r;
      t_sycxsz3_r <= sycx2_r * sz2_r;
      sy3_r       <= sy2_r;

      m4_r[0] <= p_cycz3_r;
      m4_r[1] <= p_cysz3_r;
      m4_r[2] <= -(prod_t'(sy3_r) <<< 30);
      m4_r[3] <= t_sysxcz3_r - p_szcx3_r;
      m4_r[4] <= t_sysxsz3_r + p_czcx3_r;
      m4_r[5] <= p_cysx3_r;
      m4_r[6] <= t_sycxcz3_r + p_szsx3_r;
      m4_r[7] <= t_sycxsz3_r - p_czsx3_r;
      m4_r[8] <= p_cycx3_r;

      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          m5_r[r*3+k] <= to_coef(ctl_r[3].cmd ? m4_r[k*3+r] : m4_r[r*3+k]);
        end
      end
    end
  end

  assign ctl_o = ctl_r[MAT_STAGES-1];
  assign m_o   = m5_r;

endmodule

FILE: tb/tb_euler_321_to_dcm_core.sv
// Testbench for euler_321_to_dcm_core: directed table and random attitudes vs a predictor.
module tb_euler_321_to_dcm_core;
  import e321_pkg::*;

  localparam int N_RANDOM   = 1200;
  localparam int IDLE_LIMIT = 20000;
  localparam int LATENCY    = 37;

  typedef struct {
    logic  has_m;
    logic  cmd;
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
    coef_t m [9];
  } attitude_row_t;

  typedef struct {
    coef_t m [9];
  } dcm_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_cmd;
  angle_t in_roll_angle;
  angle_t in_pitch_angle;
  angle_t in_yaw_angle;
  logic   out_valid;
  logic   out_ready;
  coef_t  out_m [9];

  dcm_t        dcm_queue [$];
  int          mismatch_count;
  int          idle_cycles;
  logic        timed_out;
  attitude_row_t directed [$];

  euler_321_to_dcm_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_roll_angle (in_roll_angle),
    .in_pitch_angle(in_pitch_angle),
    .in_yaw_angle  (in_yaw_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_m00       (out_m[0]),
    .out_m01       (out_m[1]),
    .out_m02       (out_m[2]),
    .out_m10       (out_m[3]),
    .out_m11       (out_m[4]),
    .out_m12       (out_m[5]),
    .out_m20       (out_m[6]),
    .out_m21       (out_m[7]),
    .out_m22       (out_m[8])
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint floor_div_pow2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void angle_sin_cos(angle_t ang, output longint c, output longint s);
    logic [31:0] a;
    logic [31:0] q;
    logic [31:0] u;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    a = {ang, 16'h0000};
    q = (a + 32'h2000_0000) >> 30;
    u = a - (q << 30);
    z = longint'($signed(u));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_div_pow2(y, i);
      dy = floor_div_pow2(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TAB[i]);
      end
    end
    case (q[1:0])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic coef_t round_sat_q14(longint v);
    longint r;
    r = (v + (64'sd1 <<< (59 - COEF_FRAC_BITS))) >>> (60 - COEF_FRAC_BITS);
    if (r > (64'sd1 <<< COEF_FRAC_BITS)) r = 64'sd1 <<< COEF_FRAC_BITS;
    if (r < -(64'sd1 <<< COEF_FRAC_BITS)) r = -(64'sd1 <<< COEF_FRAC_BITS);
    return coef_t'(r);
  endfunction

  function automatic dcm_t predict_dcm(logic cmd, angle_t roll, angle_t pitch, angle_t yaw);
    longint cx, sx, cy, sy, cz, sz, sysx, sycx;
    longint m [9];
    dcm_t d;
    angle_sin_cos(roll, cx, sx);
    angle_sin_cos(pitch, cy, sy);
    angle_sin_cos(yaw, cz, sz);
    sysx = (sy * sx + (64'sd1 <<< 29)) >>> 30;
    sycx = (sy * cx + (64'sd1 <<< 29)) >>> 30;
    m[0] = cy * cz;
    m[1] = cy * sz;
    m[2] = -sy * (64'sd1 <<< 30);
    m[3] = sysx * cz - sz * cx;
    m[4] = sysx * sz + cz * cx;
    m[5] = cy * sx;
    m[6] = sycx * cz + sz * sx;
    m[7] = sycx * sz - cz * sx;
    m[8] = cy * cx;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        d.m[r*3+k] = round_sat_q14(cmd ? m[k*3+r] : m[r*3+k]);
      end
    end
    return d;
  endfunction

  function automatic attitude_row_t make_row(logic cmd, int roll, int pitch, int yaw);
    attitude_row_t row;
    row.has_m = 1'b0;
    row.cmd   = cmd;
    row.roll  = angle_t'(roll);
    row.pitch = angle_t'(pitch);
    row.yaw   = angle_t'(yaw);
    for (int i = 0; i < 9; i++) row.m[i] = '0;
    return row;
  endfunction

  function automatic attitude_row_t make_identity_row(logic cmd);
    attitude_row_t row;
    row = make_row(cmd, 0, 0, 0);
    row.has_m = 1'b1;
    row.m = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
              16'sd0, 16'sd0, 16'sd16384};
    return row;
  endfunction

  task automatic drive_attitude(logic cmd, angle_t roll, angle_t pitch, angle_t yaw);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_roll_angle  <= roll;
    in_pitch_angle <= pitch;
    in_yaw_angle   <= yaw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_attitude(attitude_row_t row);
    dcm_t d;
    if (row.has_m) d.m = row.m;
    else d = predict_dcm(row.cmd, row.roll, row.pitch, row.yaw);
    dcm_queue.push_back(d);
    drive_attitude(row.cmd, row.roll, row.pitch, row.yaw);
  endtask

  function automatic int pick_angle();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) * 16384 - 32768;
      1: return $urandom_range(0, 3) * 16384 - 32768 + $urandom_range(0, 6) - 3;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  initial begin
    int burst;
    attitude_row_t row;
    in_valid       = 1'b0;
    in_cmd         = 1'b0;
    in_roll_angle  = '0;
    in_pitch_angle = '0;
    in_yaw_angle   = '0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed.push_back(make_identity_row(1'b0));
    directed.push_back(make_identity_row(1'b1));
    directed.push_back(make_row(1'b0, -32768, 0, 0));
    directed.push_back(make_row(1'b1, 0, -32768, 0));
    directed.push_back(make_row(1'b0, 0, 0, -32768));
    directed.push_back(make_row(1'b0, 32767, 32767, 32767));
    directed.push_back(make_row(1'b1, 32767, 32767, 32767));
    directed.push_back(make_row(1'b0, -32768, -32768, -32768));
    directed.push_back(make_row(1'b1, -32768, -32768, -32768));
    directed.push_back(make_row(1'b0, 16384, 0, 0));
    directed.push_back(make_row(1'b0, 0, 16384, 0));
    directed.push_back(make_row(1'b0, 0, -16384, 0));
    directed.push_back(make_row(1'b1, 0, 0, 16384));
    directed.push_back(make_row(1'b1, 8192, 8192, 8192));
    directed.push_back(make_row(1'b0, 16383, 16385, -16383));
    directed.push_back(make_row(1'b1, 1, -1, 2));
    directed.push_back(make_row(1'b0, -21845, 5461, 12345));
    directed.push_back(make_row(1'b1, 21845, -5461, -12345));
    directed.push_back(make_row(1'b0, 4096, 24576, -8192));
    directed.push_back(make_row(1'b1, -4096, -24576, 8192));
    foreach (directed[i]) send_attitude(directed[i]);

    for (int n = 0; n < N_RANDOM; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        row = make_row(1'($urandom_range(0, 1)), pick_angle(), pick_angle(), pick_angle());
        send_attitude(row);
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      case ($urandom_range(0, 3))
        0: out_ready <= ($urandom_range(0, 1) == 1);
        1: out_ready <= ($urandom_range(0, 4) != 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    dcm_t d;
    logic bad;
    if (rst_n && out_valid && out_ready) begin
      if (dcm_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result with nothing pending");
      end else begin
        d = dcm_queue.pop_front();
        bad = 1'b0;
        for (int i = 0; i < 9; i++) if (out_m[i] !== d.m[i]) bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            for (int i = 0; i < 9; i++) begin
              $display("entry %0d: expected %0d actual %0d", i, d.m[i], out_m[i]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out = 1'b0;
    @(posedge rst_n);
    repeat (2) @(posedge clk);
    while ((in_valid || dcm_queue.size() != 0) && idle_cycles < IDLE_LIMIT) @(posedge clk);
    while (!timed_out) begin
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
      else if (!in_valid && dcm_queue.size() == 0) break;
      else @(posedge clk);
    end
    if (!timed_out) repeat (2 * LATENCY) @(posedge clk);
    if (!timed_out && mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: euler_321_to_dcm_core.f
+incdir+design
design/e321_pkg.sv
design/e321_sincos.sv
design/e321_matrix.sv
design/euler_321_to_dcm_core.sv
tb/tb_euler_321_to_dcm_core.sv
